// ===== sv/bracket_matching_program_loader_defines.svh =====
// Assertion macros for the bracket matching program loader.
`ifndef BRACKET_MATCHING_PROGRAM_LOADER_DEFINES_SVH
`define BRACKET_MATCHING_PROGRAM_LOADER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BMPL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmpl: property failed");
// next-cycle implication
`define BMPL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmpl: property failed");
`else
`define BMPL_ASSERT_NOW(name, ante, cons)
`define BMPL_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/bmpl_pkg.sv =====
// Shared types, constants and functions of the bracket matching program loader.
package bmpl_pkg;

  localparam int DEF_PROGRAM_DEPTH = 4096;
  localparam int DEF_NEST_DEPTH    = 256;
  localparam int DEF_LABEL_BITS    = 16;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 12;
  localparam int OP_W     = 3;
  localparam int LABEL_W  = 16;
  localparam int STATUS_W = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_PATCH  = 2'd1,
    KIND_STATUS = 2'd2
  } record_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_UNMATCHED_OPEN  = 3'd2,
    ST_FULL            = 3'd3,
    ST_TOO_DEEP        = 3'd4
  } status_t;

  typedef struct packed {
    logic    is_cmd;
    opcode_t op;
  } char_class_t;

  typedef struct packed {
    logic    is_end;
    opcode_t op;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic char_class_t classify_char(input logic [7:0] ch);
    char_class_t c;
    c.is_cmd = 1'b1;
    unique case (ch)
      8'h3E:   c.op = OP_RIGHT;
      8'h3C:   c.op = OP_LEFT;
      8'h2B:   c.op = OP_INC;
      8'h2D:   c.op = OP_DEC;
      8'h2E:   c.op = OP_OUT;
      8'h2C:   c.op = OP_IN;
      8'h5B:   c.op = OP_OPEN;
      8'h5D:   c.op = OP_CLOSE;
      default: begin
        c.is_cmd = 1'b0;
        c.op     = OP_RIGHT;
      end
    endcase
    return c;
  endfunction

  function automatic logic [POS_W-1:0] fit_pos(input logic [31:0] v);
    return v[POS_W-1:0];
  endfunction

  function automatic logic [LABEL_W-1:0] fit_label(input logic [31:0] v);
    return v[LABEL_W-1:0];
  endfunction

endpackage

// ===== sv/bmpl_if.sv =====
// Channel interfaces: source characters in, loader records out.
interface bmpl_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] source_char;

  modport source (output valid, command, source_char, input ready);
  modport sink   (input valid, command, source_char, output ready);
endinterface

interface bmpl_out_if import bmpl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   record_kind;
  logic [POS_W-1:0]    position;
  logic [OP_W-1:0]     opcode;
  logic [LABEL_W-1:0]  label;
  logic [POS_W-1:0]    jump_target;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, record_kind, position, opcode, label, jump_target, status,
                  last, input ready);
  modport sink   (input valid, record_kind, position, opcode, label, jump_target, status,
                  last, output ready);
endinterface

// ===== sv/bracket_matching_program_loader.sv =====
// Bracket matching program loader for an eight-command tape language. The src channel takes
// one source character per cycle into a four-entry queue while that queue is not full;
// characters that are not commands are dropped at the input and never reach the back
// end. The back end retires one queued command per cycle while dst is ready, except a close
// bracket, which reads the bracket stack (one registered memory read) and sends two records,
// entry then patch, through the single output register before the next item is taken. An end
// item (command = 1) sends the final status record and returns all counters to reset. The
// stack memory has no reset and needs no clearing pass; the block accepts items right after
// reset.
`include "bracket_matching_program_loader_defines.svh"

module bracket_matching_program_loader import bmpl_pkg::*; #(
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int NEST_DEPTH    = DEF_NEST_DEPTH,
  parameter int LABEL_BITS    = DEF_LABEL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  bmpl_in_if.sink    src,
  bmpl_out_if.source dst
);

  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;
  q_entry_t q_in;
  q_entry_t q_out;

  logic     close_xfer;
  logic     patch_shown;
  logic     status_shown;
  logic     status_clean;

  bmpl_front u_front (
    .src    (src),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_in)
  );

  bmpl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .q_stat    (q_stat)
  );

  bmpl_back #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .NEST_DEPTH    (NEST_DEPTH),
    .LABEL_BITS    (LABEL_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (q_out),
    .q_pop  (q_pop),
    .dst    (dst)
  );

  assign close_xfer   = dst.valid && dst.ready && dst.record_kind == KIND_ENTRY &&
                        dst.opcode == OP_CLOSE;
  assign patch_shown  = dst.valid && dst.record_kind == KIND_PATCH && dst.last;
  assign status_shown = dst.valid && dst.record_kind == KIND_STATUS;
  assign status_clean = dst.last && dst.position == '0 && dst.label == '0;

  `BMPL_ASSERT_NOW(a_queue_no_overflow, q_stat.full, !q_push)
  `BMPL_ASSERT_NOW(a_no_pop_empty, q_stat.empty, !q_pop)
  `BMPL_ASSERT_NEXT(a_close_then_patch, close_xfer, patch_shown)
  `BMPL_ASSERT_NOW(a_status_record_clean, status_shown, status_clean)

endmodule

// ===== sv/bmpl_front.sv =====
// Front end: takes source characters, drops non-commands, pushes commands and ends.
module bmpl_front import bmpl_pkg::*; (
  bmpl_in_if.sink  src,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_data
);

  char_class_t cls;

  always_comb begin
    cls       = classify_char(src.source_char);
    src.ready = !q_stat.full;
    // drop characters that are not commands, keep every end marker
    q_push    = src.valid && !q_stat.full && (src.command || cls.is_cmd);
    q_data.is_end = src.command;
    q_data.op     = src.command ? OP_RIGHT : cls.op;
  end

endmodule

// ===== sv/bmpl_queue.sv =====
// Short queue between the front end and the execution back end.
module bmpl_queue import bmpl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output q_stat_t  q_stat
);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop)      count <= count + QCW'(1);
      else if (pop && !push) count <= count - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_comb begin
    pop_data     = entries[rd_ptr];
    q_stat.full  = (count == QCW'(QUEUE_DEPTH));
    q_stat.empty = (count == '0);
  end

endmodule

// ===== sv/bmpl_back.sv =====
// Back end: bracket stack, position and label counters, output record register.
module bmpl_back import bmpl_pkg::*; #(
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int NEST_DEPTH    = DEF_NEST_DEPTH,
  parameter int LABEL_BITS    = DEF_LABEL_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  q_stat_t   q_stat,
  input  q_entry_t  q_data,
  output logic      q_pop,
  bmpl_out_if.source dst
);

  localparam int PW  = $clog2(PROGRAM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int AW  = $clog2(NEST_DEPTH);
  localparam int DW  = $clog2(NEST_DEPTH + 1);
  localparam int EW  = LABEL_BITS + PW;

  // architectural state
  logic [DW-1:0]         depth, depth_next;
  logic [PCW-1:0]        next_pos, next_pos_next;
  logic [LABEL_BITS-1:0] next_label, next_label_next;
  status_t               err, err_next;

  // bracket stack
  logic [EW-1:0] stack_mem [NEST_DEPTH];
  logic [EW-1:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] depth_m1;

  // output record register
  logic                  w_valid;
  logic                  w_close;
  logic                  w_phase;
  record_kind_t          w_kind;
  opcode_t               w_op;
  logic [PW-1:0]         w_pos;
  logic [LABEL_BITS-1:0] w_label;
  status_t               w_status;

  logic                  load_w;
  logic                  lw_close;
  record_kind_t          lw_kind;
  opcode_t               lw_op;
  logic [PW-1:0]         lw_pos;
  logic [LABEL_BITS-1:0] lw_label;
  status_t               lw_status;

  logic                  w_last_out;
  logic                  w_free;
  logic                  pos_full;
  logic [PW-1:0]         here;
  logic [LABEL_BITS-1:0] rd_label;
  logic [PW-1:0]         rd_pos;

  assign w_last_out = !w_close || w_phase;
  assign w_free     = !w_valid || (dst.ready && w_last_out);
  assign q_pop      = !q_stat.empty && w_free;
  assign pos_full   = (next_pos == PCW'(PROGRAM_DEPTH));
  assign here       = next_pos[PW-1:0];
  assign depth_m1   = depth - DW'(1);

  always_comb begin
    depth_next      = depth;
    next_pos_next   = next_pos;
    next_label_next = next_label;
    err_next        = err;
    mem_we          = 1'b0;
    mem_wa          = depth[AW-1:0];
    mem_wd          = {next_label, here};
    rd_en           = 1'b0;
    rd_addr         = depth_m1[AW-1:0];
    load_w          = 1'b0;
    lw_close        = 1'b0;
    lw_kind         = KIND_ENTRY;
    lw_op           = q_data.op;
    lw_pos          = here;
    lw_label        = '0;
    lw_status       = ST_OK;
    if (q_pop) begin
      if (q_data.is_end) begin
        load_w = 1'b1;
        lw_kind = KIND_STATUS;
        lw_op   = OP_RIGHT;
        lw_pos  = '0;
        if (err != ST_OK)      lw_status = err;
        else if (depth != '0)  lw_status = ST_UNMATCHED_OPEN;
        else                   lw_status = ST_OK;
        depth_next      = '0;
        next_pos_next   = '0;
        next_label_next = '0;
        err_next        = ST_OK;
      end else if (err == ST_OK) begin
        priority if (q_data.op == OP_CLOSE) begin
          if (depth == '0) begin
            err_next = ST_UNMATCHED_CLOSE;
          end else if (pos_full) begin
            err_next = ST_FULL;
          end else begin
            // pop: stack top arrives in rd_data next cycle
            rd_en         = 1'b1;
            depth_next    = depth_m1;
            next_pos_next = next_pos + PCW'(1);
            load_w        = 1'b1;
            lw_close      = 1'b1;
          end
        end else if (pos_full) begin
          err_next = ST_FULL;
        end else if (q_data.op == OP_OPEN) begin
          if (depth == DW'(NEST_DEPTH)) begin
            err_next = ST_TOO_DEEP;
          end else begin
            mem_we          = 1'b1;
            depth_next      = depth + DW'(1);
            next_pos_next   = next_pos + PCW'(1);
            next_label_next = next_label + LABEL_BITS'(1);
            load_w          = 1'b1;
            lw_label        = next_label;
          end
        end else begin
          next_pos_next = next_pos + PCW'(1);
          load_w        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      next_pos   <= '0;
      next_label <= '0;
      err        <= ST_OK;
    end else begin
      depth      <= depth_next;
      next_pos   <= next_pos_next;
      next_label <= next_label_next;
      err        <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (rd_en)  rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      w_phase <= 1'b0;
    end else if (load_w) begin
      w_valid <= 1'b1;
      w_phase <= 1'b0;
    end else if (w_valid && dst.ready) begin
      // a close bracket holds for its patch record
      if (w_last_out) w_valid <= 1'b0;
      else            w_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      w_close  <= lw_close;
      w_kind   <= lw_kind;
      w_op     <= lw_op;
      w_pos    <= lw_pos;
      w_label  <= lw_label;
      w_status <= lw_status;
    end
  end

  assign rd_label = rd_data[EW-1:PW];
  assign rd_pos   = rd_data[PW-1:0];

  always_comb begin
    dst.valid = w_valid;
    if (!w_close) begin
      dst.record_kind = w_kind;
      dst.position    = fit_pos(32'(w_pos));
      dst.opcode      = w_op;
      dst.label       = fit_label(32'(w_label));
      dst.jump_target = '0;
      dst.status      = w_status;
      dst.last        = 1'b1;
    end else if (!w_phase) begin
      dst.record_kind = KIND_ENTRY;
      dst.position    = fit_pos(32'(w_pos));
      dst.opcode      = OP_CLOSE;
      dst.label       = fit_label(32'(rd_label));
      dst.jump_target = fit_pos(32'(rd_pos));
      dst.status      = ST_OK;
      dst.last        = 1'b0;
    end else begin
      dst.record_kind = KIND_PATCH;
      dst.position    = fit_pos(32'(rd_pos));
      dst.opcode      = OP_OPEN;
      dst.label       = fit_label(32'(rd_label));
      dst.jump_target = fit_pos(32'(w_pos));
      dst.status      = ST_OK;
      dst.last        = 1'b1;
    end
  end

endmodule
